FILE: rtl/ats_pkg.sv
package ats_pkg;

  // Token kind codes as they appear on the result channel.
  localparam logic [3:0] K_WORD    = 4'd0;
  localparam logic [3:0] K_DEC     = 4'd1;
  localparam logic [3:0] K_HEX     = 4'd2;
  localparam logic [3:0] K_COMMA   = 4'd3;
  localparam logic [3:0] K_COLON   = 4'd4;
  localparam logic [3:0] K_PLUS    = 4'd5;
  localparam logic [3:0] K_MINUS   = 4'd6;
  localparam logic [3:0] K_EOL     = 4'd7;
  localparam logic [3:0] K_END     = 4'd8;
  localparam logic [3:0] K_BADCHAR = 4'd9;
  localparam logic [3:0] K_BADNUM  = 4'd10;

  // Scanner state codes.
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_WORD    = 3'd1;
  localparam logic [2:0] M_ZERO    = 3'd2;
  localparam logic [2:0] M_DEC     = 3'd3;
  localparam logic [2:0] M_HEX     = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;
  localparam logic [2:0] M_HALT    = 3'd6;

  // Character codes the scanner looks for.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOWX  = 8'h78;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWF  = 8'h66;
  localparam logic [7:0] CH_LOWZ  = 8'h7A;

  // One result item.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  length;
    logic [15:0] line_no;
    logic        last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LOWA && c <= CH_LOWZ) || (c >= CH_UPA && c <= CH_UPZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= CH_LOWA && c <= CH_LOWF) || (c >= CH_UPA && c <= CH_UPF);
  endfunction

endpackage

FILE: rtl/ats_if.sv
// Character request channel.
interface ats_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// Token request channel.
interface ats_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  length;
  logic [15:0] line_no;
  logic        last;

  modport source (output valid, output kind, output length, output line_no, output last,
                  input ready);
  modport sink (input valid, input kind, input length, input line_no, input last,
                output ready);
endinterface

FILE: rtl/ats_classify.sv
// Classifies one character against the scanner state and works out the next
// state together with up to two tokens: the one the character ends and the
// one it starts.
module ats_classify #(
  parameter int LINE_WIDTH   = 16,
  parameter int LENGTH_WIDTH = 8
) (
  input  logic [7:0]              ch,
  input  logic [2:0]              mode,
  input  logic [LENGTH_WIDTH-1:0] tok_len,
  input  logic [LINE_WIDTH-1:0]   line_num,
  input  logic                    line_tok,
  output logic [2:0]              mode_next,
  output logic [LENGTH_WIDTH-1:0] tok_len_next,
  output logic [LINE_WIDTH-1:0]   line_num_next,
  output logic                    line_tok_next,
  output logic [1:0]              res_cnt,
  output ats_pkg::res_t           res0,
  output ats_pkg::res_t           res1
);

  logic                    letter, digit, hexd, tail, word_ch;
  logic [LENGTH_WIDTH-1:0] len_inc;
  logic [LINE_WIDTH-1:0]   line_inc;
  logic [15:0]             line_out;
  logic                    p_valid;
  logic [3:0]              p_kind;
  logic                    do_start;
  logic [2:0]              s_mode;
  logic [LENGTH_WIDTH-1:0] s_len;
  logic                    s_valid;
  logic [3:0]              s_kind;
  logic [7:0]              s_out_len;
  logic                    s_newline;

  // Character classes and saturating counters.
  assign letter   = ats_pkg::is_letter(ch);
  assign digit    = ats_pkg::is_digit(ch);
  assign hexd     = ats_pkg::is_hex(ch);
  assign tail     = letter || (ch == ats_pkg::CH_UNDER);
  assign word_ch  = tail || digit;
  assign len_inc  = (tok_len == '1) ? tok_len : tok_len + LENGTH_WIDTH'(1);
  assign line_inc = (line_num == '1) ? line_num : line_num + LINE_WIDTH'(1);
  assign line_out = 16'(line_num);

  // What the character does as the first character of a new token.
  always_comb begin
    s_mode    = ats_pkg::M_IDLE;
    s_len     = '0;
    s_valid   = 1'b0;
    s_kind    = ats_pkg::K_BADCHAR;
    s_out_len = 8'd1;
    s_newline = 1'b0;
    priority if (letter) begin
      s_mode = ats_pkg::M_WORD;
      s_len  = LENGTH_WIDTH'(1);
    end else if (ch == ats_pkg::CH_ZERO) begin
      s_mode = ats_pkg::M_ZERO;
      s_len  = LENGTH_WIDTH'(1);
    end else if (digit) begin
      s_mode = ats_pkg::M_DEC;
      s_len  = LENGTH_WIDTH'(1);
    end else if (ch == ats_pkg::CH_SPACE || ch == ats_pkg::CH_TAB) begin
      s_mode = ats_pkg::M_IDLE;
    end else if (ch == ats_pkg::CH_SEMI) begin
      s_mode = ats_pkg::M_COMMENT;
    end else if (ch == ats_pkg::CH_COMMA) begin
      s_valid = 1'b1;
      s_kind  = ats_pkg::K_COMMA;
    end else if (ch == ats_pkg::CH_COLON) begin
      s_valid = 1'b1;
      s_kind  = ats_pkg::K_COLON;
    end else if (ch == ats_pkg::CH_PLUS) begin
      s_valid = 1'b1;
      s_kind  = ats_pkg::K_PLUS;
    end else if (ch == ats_pkg::CH_MINUS) begin
      s_valid = 1'b1;
      s_kind  = ats_pkg::K_MINUS;
    end else if (ch == ats_pkg::CH_LF) begin
      // An end of line counts only for a line that produced a token, which
      // includes a token the newline itself just closed.
      s_newline = 1'b1;
      s_valid   = line_tok || p_valid;
      s_kind    = ats_pkg::K_EOL;
    end else if (ch == ats_pkg::CH_NUL) begin
      s_valid   = 1'b1;
      s_kind    = ats_pkg::K_END;
      s_out_len = 8'd0;
      s_mode    = ats_pkg::M_HALT;
    end else begin
      s_valid = 1'b1;
      s_kind  = ats_pkg::K_BADCHAR;
      s_mode  = ats_pkg::M_HALT;
    end
  end

  // Continue the current token, or close it and restart on this character.
  always_comb begin
    mode_next    = mode;
    tok_len_next = tok_len;
    p_valid      = 1'b0;
    p_kind       = ats_pkg::K_WORD;
    do_start     = 1'b0;
    unique case (mode)
      ats_pkg::M_HALT: begin
        mode_next = ats_pkg::M_HALT;
      end
      ats_pkg::M_WORD: begin
        if (word_ch) begin
          tok_len_next = len_inc;
        end else begin
          p_valid  = 1'b1;
          p_kind   = ats_pkg::K_WORD;
          do_start = 1'b1;
        end
      end
      ats_pkg::M_ZERO: begin
        priority if (ch == ats_pkg::CH_LOWX || ch == ats_pkg::CH_UPX) begin
          mode_next    = ats_pkg::M_HEX;
          tok_len_next = '0;
        end else if (digit) begin
          mode_next    = ats_pkg::M_DEC;
          tok_len_next = len_inc;
        end else if (tail) begin
          p_valid   = 1'b1;
          p_kind    = ats_pkg::K_BADNUM;
          mode_next = ats_pkg::M_HALT;
        end else begin
          p_valid  = 1'b1;
          p_kind   = ats_pkg::K_DEC;
          do_start = 1'b1;
        end
      end
      ats_pkg::M_DEC: begin
        priority if (digit) begin
          tok_len_next = len_inc;
        end else if (tail) begin
          p_valid   = 1'b1;
          p_kind    = ats_pkg::K_BADNUM;
          mode_next = ats_pkg::M_HALT;
        end else begin
          p_valid  = 1'b1;
          p_kind   = ats_pkg::K_DEC;
          do_start = 1'b1;
        end
      end
      ats_pkg::M_HEX: begin
        priority if (hexd) begin
          tok_len_next = len_inc;
        end else if (tail) begin
          p_valid   = 1'b1;
          p_kind    = ats_pkg::K_BADNUM;
          mode_next = ats_pkg::M_HALT;
        end else begin
          p_valid  = 1'b1;
          p_kind   = ats_pkg::K_HEX;
          do_start = 1'b1;
        end
      end
      ats_pkg::M_COMMENT: begin
        do_start = (ch == ats_pkg::CH_LF) || (ch == ats_pkg::CH_NUL);
      end
      default: begin
        do_start = 1'b1;
      end
    endcase
    if (do_start) begin
      mode_next    = s_mode;
      tok_len_next = s_len;
    end
  end

  // Line bookkeeping.
  always_comb begin
    line_num_next = line_num;
    line_tok_next = line_tok || p_valid;
    if (do_start) begin
      if (s_newline) begin
        line_num_next = line_inc;
        line_tok_next = 1'b0;
      end else begin
        line_tok_next = line_tok || p_valid || s_valid;
      end
    end
  end

  // Pack the tokens: the closed token goes first when there is one.
  always_comb begin
    res_cnt = 2'(p_valid) + 2'(do_start && s_valid);
    res1.kind    = s_kind;
    res1.length  = s_out_len;
    res1.line_no = line_out;
    res1.last    = 1'b1;
    if (p_valid) begin
      res0.kind    = p_kind;
      res0.length  = 8'(tok_len);
      res0.line_no = line_out;
      res0.last    = !(do_start && s_valid);
    end else begin
      res0 = res1;
    end
  end

endmodule

FILE: rtl/ats_res_buf.sv
// Two-entry result register. It takes the tokens of one character at a time
// and hands them out one per request, oldest first.
module ats_res_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [1:0]      load_cnt,
  input  ats_pkg::res_t   load0,
  input  ats_pkg::res_t   load1,
  output logic            can_load,
  ats_tok_if.source       tok
);

  ats_pkg::res_t slot0;
  ats_pkg::res_t slot1;
  logic [1:0]    cnt;
  logic          pop;

  assign pop      = tok.valid && tok.ready;
  assign can_load = (cnt == 2'd0) || (cnt == 2'd1 && tok.ready);

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Token slots.
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= load0;
      slot1 <= load1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign tok.valid   = (cnt != 2'd0);
  assign tok.kind    = slot0.kind;
  assign tok.length  = slot0.length;
  assign tok.line_no = slot0.line_no;
  assign tok.last    = slot0.last;

endmodule

FILE: rtl/assembler_token_scanner.sv
// Assembler token scanner: takes source text one character per request and
// returns tokens (words, decimal and 0x hex numbers, punctuation, end of line,
// end of text, errors), each with its length and line number; the first token
// of a character is offered in the cycle after the character is taken. A
// character is taken every cycle while the token side is ready and each one
// closes or opens at most one token; a character that both ends a token and
// yields one of its own gives two tokens, and the next character then waits
// while the two-entry result register drains one token per ready cycle. A zero
// byte, a bad character or a malformed number stops the scanner until reset.
module assembler_token_scanner #(
  parameter int LINE_WIDTH   = 16,
  parameter int LENGTH_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  ats_char_if.sink  src,
  ats_tok_if.source tok
);

  logic [2:0]              mode;
  logic [LENGTH_WIDTH-1:0] tok_len;
  logic [LINE_WIDTH-1:0]   line_num;
  logic                    line_tok;
  logic [2:0]              mode_next;
  logic [LENGTH_WIDTH-1:0] tok_len_next;
  logic [LINE_WIDTH-1:0]   line_num_next;
  logic                    line_tok_next;
  logic [1:0]              res_cnt;
  ats_pkg::res_t           res0;
  ats_pkg::res_t           res1;
  logic                    can_load;
  logic                    accept;

  assign src.ready = can_load;
  assign accept    = src.valid && src.ready;

  ats_classify #(
    .LINE_WIDTH   (LINE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_classify (
    .ch            (src.ch),
    .mode          (mode),
    .tok_len       (tok_len),
    .line_num      (line_num),
    .line_tok      (line_tok),
    .mode_next     (mode_next),
    .tok_len_next  (tok_len_next),
    .line_num_next (line_num_next),
    .line_tok_next (line_tok_next),
    .res_cnt       (res_cnt),
    .res0          (res0),
    .res1          (res1)
  );

  // Scanner state advances on each accepted character.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= ats_pkg::M_IDLE;
      tok_len  <= '0;
      line_num <= LINE_WIDTH'(1);
      line_tok <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      tok_len  <= tok_len_next;
      line_num <= line_num_next;
      line_tok <= line_tok_next;
    end
  end

  ats_res_buf u_res_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .load_cnt (res_cnt),
    .load0    (res0),
    .load1    (res1),
    .can_load (can_load),
    .tok      (tok)
  );

endmodule

FILE: rtl/ats_checker.sv
// Port-level checks for the token scanner.
module ats_checker (
  input logic        clk,
  input logic        rst,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [3:0]  tok_kind,
  input logic [7:0]  tok_length,
  input logic [15:0] tok_line_no,
  input logic        tok_last
);

  logic halted;
  logic terminal;

  assign terminal = tok_kind == ats_pkg::K_END || tok_kind == ats_pkg::K_BADCHAR ||
                    tok_kind == ats_pkg::K_BADNUM;

  // Remember that a stopping token has been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (tok_valid && tok_ready && terminal) begin
      halted <= 1'b1;
    end
  end

  // A stalled token holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_length) &&
                                $stable(tok_line_no) && $stable(tok_last))
    else $error("token changed while stalled");

  // Nothing follows a stopping token.
  a_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !tok_valid)
    else $error("token after scanner stopped");

  // A stopping token is always the final one of its character.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && terminal |-> tok_last)
    else $error("stopping token not marked last");

  // Kind stays within the defined codes.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> tok_kind <= ats_pkg::K_BADNUM)
    else $error("undefined token kind");

  // No token right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !tok_valid)
    else $error("token present after reset");

endmodule

bind assembler_token_scanner ats_checker u_ats_checker (
  .clk         (clk),
  .rst         (rst),
  .tok_valid   (tok.valid),
  .tok_ready   (tok.ready),
  .tok_kind    (tok.kind),
  .tok_length  (tok.length),
  .tok_line_no (tok.line_no),
  .tok_last    (tok.last)
);
